// ===== rtl/pltb_pkg.sv =====
// pltb_pkg: shared types and constants of the point light tile brightness block
// used by every module under rtl except pltb_ram; depends on nothing
`default_nettype none

package pltb_pkg;

   // field widths of the stream beats
   localparam int COORD_W    = 12;
   localparam int SLOT_IDX_W = 4;
   localparam int REACH_W    = 8;
   localparam int BASE_W     = 8;
   localparam int BRIGHT_W   = 8;

   // packed beat widths, padded to whole bytes
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;

   // function codes carried on req_tuser
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // squared distance and square root
   localparam int SUM_W       = 25;
   localparam int ROOT_W      = 13;
   localparam int SQRT_STAGES = 13;

   // contribution = (reach - d) * base / 2
   localparam int CONTRIB_W = REACH_W + BASE_W - 1;
   localparam logic [BRIGHT_W-1:0] BRIGHT_CEIL = 8'd255;

   // tile distance by reciprocal multiply, exact for roots below 2**ROOT_W
   localparam int DIV_SHIFT = ROOT_W + 8;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = ROOT_W + RECIP_W;

   // one command in the queue between front and back
   typedef struct packed {
      logic                  is_query;
      logic                  enable;
      logic [SLOT_IDX_W-1:0] slot;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [REACH_W-1:0]    reach;
      logic [BASE_W-1:0]     base;
   } cmd_type;

   // one light table entry
   typedef struct packed {
      logic [BASE_W-1:0]  base;
      logic [REACH_W-1:0] reach;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } entry_type;

   // per-slot tag that rides along the distance pipeline
   typedef struct packed {
      logic               act;
      logic               last;
      logic               lv;
      logic [REACH_W-1:0] reach;
      logic [BASE_W-1:0]  base;
   } light_tag_type;

   // one query result
   typedef struct packed {
      logic                any;
      logic [BRIGHT_W-1:0] bright;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/pltb_ram.sv =====
// pltb_ram: generic single write port, single read port ram with registered read
// standalone, no package needed
`default_nettype none

module pltb_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pltb_sqrt.sv =====
// pltb_sqrt: pipelined integer floor square root, one result bit per stage
// depends on pltb_pkg for widths and the light tag type
`default_nettype none

module pltb_sqrt
   import pltb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SUM_W-1:0]    v_i,
   input  wire light_tag_type       tag_i,
   output logic      [ROOT_W-1:0]   root_o,
   output light_tag_type            tag_o
);

   logic [SUM_W-1:0] v_ff    [1:SQRT_STAGES];
   logic [SUM_W-1:0] root_ff [1:SQRT_STAGES];
   light_tag_type    tag_ff  [1:SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STAGES - 1 - k));
      logic [SUM_W-1:0] v_src;
      logic [SUM_W-1:0] root_src;
      light_tag_type    tag_src;
      logic [SUM_W-1:0] trial;
      logic             ge;

      // stage source: pipeline input or previous stage
      if (k == 0) begin : g_first
         assign v_src    = v_i;
         assign root_src = '0;
         assign tag_src  = tag_i;
      end else begin : g_rest
         assign v_src    = v_ff[k];
         assign root_src = root_ff[k];
         assign tag_src  = tag_ff[k];
      end

      // try the current bit
      assign trial = root_src + BIT;
      assign ge    = (v_src >= trial);

      always_ff @(posedge clock) begin
         v_ff[k+1]    <= ge ? (v_src - trial) : v_src;
         root_ff[k+1] <= ge ? ((root_src >> 1) + BIT) : (root_src >> 1);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else begin
            tag_ff[k+1] <= tag_src;
         end
      end
   end

   assign root_o = root_ff[SQRT_STAGES][ROOT_W-1:0];
   assign tag_o  = tag_ff[SQRT_STAGES];

endmodule

`default_nettype wire

// ===== rtl/pltb_front.sv =====
// pltb_front: accepts request beats, classifies them and queues commands
// depends on pltb_pkg for the command type and field widths
`default_nettype none

module pltb_front
   import pltb_pkg::*;
#(
   parameter int LIGHT_SLOTS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   output logic                        cmd_valid,
   output cmd_type                     cmd,
   input  wire logic                   cmd_ready
);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            beat_cmd;
   logic [8:0]         slot_ext;
   logic               in_range;
   logic               accept;
   logic               push;
   logic               pop;

   // unpack the beat
   assign beat_cmd.is_query = (req_tuser == FUNC_QUERY);
   assign beat_cmd.slot     = req_tdata[3:0];
   assign beat_cmd.enable   = req_tdata[4];
   assign beat_cmd.x        = req_tdata[16:5];
   assign beat_cmd.y        = req_tdata[28:17];
   assign beat_cmd.reach    = req_tdata[36:29];
   assign beat_cmd.base     = req_tdata[44:37];

   // writes to slots past the table are dropped here
   assign slot_ext = {5'b0, beat_cmd.slot};
   assign in_range = (slot_ext < 9'(LIGHT_SLOTS));

   assign req_tready = (count_ff < CNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (beat_cmd.is_query || in_range);
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= beat_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pltb_back.sv =====
// pltb_back: executes queued commands; holds the light table, sweeps it for
// queries through the distance pipeline and buffers results; uses pltb_pkg,
// pltb_ram and pltb_sqrt
`default_nettype none

module pltb_back
   import pltb_pkg::*;
#(
   parameter int LIGHT_SLOTS = 16,
   parameter int TILE_PIXELS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_valid,
   input  wire cmd_type                cmd,
   output logic                        cmd_ready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int SLOT_W = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LIGHT_SLOTS - 1);
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TILE_PIXELS) - 64'd1) / 64'(TILE_PIXELS));
   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic {ST_IDLE, ST_SWEEP} state_type;

   // sequencer
   state_type          state_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [1:0]         in_flight_ff, in_flight_in;
   logic [COORD_W-1:0] qx_ff, qy_ff;
   logic [LIGHT_SLOTS-1:0] valid_ff;
   logic               pop;
   logic               pop_write;
   logic               pop_query;
   logic [8:0]         wr_slot_ext;
   logic [SLOT_W-1:0]  wr_addr;
   entry_type          wr_entry;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;
   logic               issue;

   // pipeline
   logic               iss_act_ff, iss_last_ff, iss_lv_ff;
   logic [COORD_W-1:0] iss_qx_ff, iss_qy_ff;
   logic [COORD_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   light_tag_type      tag2_ff, tag2_in;
   logic [2*COORD_W-1:0] sqx_ff, sqy_ff;
   light_tag_type      tag3_ff;
   logic [SUM_W-1:0]   sum_ff;
   light_tag_type      tag4_ff;
   logic [ROOT_W-1:0]  root;
   light_tag_type      tag5;
   logic [PROD_W-1:0]  prod_ff;
   light_tag_type      tagd_ff;
   logic [ROOT_W-1:0]  tile_dist;
   logic               hit_in;
   logic [REACH_W-1:0] diff;
   logic [REACH_W+BASE_W-1:0] scaled;
   logic               c_act_ff, c_last_ff, c_hit_ff;
   logic [CONTRIB_W-1:0] c_ff;

   // reduction and result buffer
   logic [CONTRIB_W-1:0] best_ff, best_in;
   logic               any_ff, any_in;
   logic               res_push;
   result_type         res_new;
   result_type         res_ff [2];
   logic               res_wr_ff, res_rd_ff;
   logic [1:0]         res_cnt_ff;
   logic               rsp_pop;

   // command handshake: only while idle; writes go at once, queries also need an output credit
   assign cmd_ready = (state_ff == ST_IDLE) && (!cmd.is_query || (in_flight_ff < 2'd2));
   assign pop       = cmd_valid && cmd_ready;
   assign pop_write = pop && !cmd.is_query;
   assign pop_query = pop && cmd.is_query;
   assign issue     = (state_ff == ST_SWEEP);

   // table write port
   assign wr_slot_ext    = {5'b0, cmd.slot};
   assign wr_addr        = wr_slot_ext[SLOT_W-1:0];
   assign wr_entry.x     = cmd.x;
   assign wr_entry.y     = cmd.y;
   assign wr_entry.reach = cmd.reach;
   assign wr_entry.base  = cmd.base;

   pltb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LIGHT_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (pop_write),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = rd_data;
   assign rsp_pop  = rsp_tvalid && rsp_tready;

   // outstanding query count
   always_comb begin
      in_flight_in = in_flight_ff;
      if (pop_query && !rsp_pop) begin
         in_flight_in = in_flight_ff + 2'd1;
      end else if (rsp_pop && !pop_query) begin
         in_flight_in = in_flight_ff - 2'd1;
      end
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         in_flight_ff <= '0;
         valid_ff     <= '0;
         iss_act_ff   <= 1'b0;
         iss_last_ff  <= 1'b0;
         iss_lv_ff    <= 1'b0;
      end else begin
         in_flight_ff <= in_flight_in;
         iss_act_ff   <= issue;
         iss_last_ff  <= issue && (slot_ff == LAST_SLOT);
         iss_lv_ff    <= issue && valid_ff[slot_ff];
         if (pop_write) begin
            valid_ff[wr_addr] <= cmd.enable;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_query) begin
                  state_ff <= ST_SWEEP;
                  slot_ff  <= '0;
               end
            end
            ST_SWEEP: begin
               if (slot_ff == LAST_SLOT) begin
                  state_ff <= ST_IDLE;
               end else begin
                  slot_ff <= slot_ff + SLOT_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // query position, held for the sweep
   always_ff @(posedge clock) begin
      if (pop_query) begin
         qx_ff <= cmd.x;
         qy_ff <= cmd.y;
      end
      iss_qx_ff <= qx_ff;
      iss_qy_ff <= qy_ff;
   end

   // absolute coordinate differences
   assign dx_in = (rd_entry.x > iss_qx_ff) ? (rd_entry.x - iss_qx_ff) : (iss_qx_ff - rd_entry.x);
   assign dy_in = (rd_entry.y > iss_qy_ff) ? (rd_entry.y - iss_qy_ff) : (iss_qy_ff - rd_entry.y);
   assign tag2_in.act   = iss_act_ff;
   assign tag2_in.last  = iss_last_ff;
   assign tag2_in.lv    = iss_lv_ff;
   assign tag2_in.reach = rd_entry.reach;
   assign tag2_in.base  = rd_entry.base;

   // data path registers
   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      sum_ff  <= SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      prod_ff <= PROD_W'(root) * PROD_W'(RECIP);
      c_ff    <= CONTRIB_W'(scaled >> 1);
   end

   // tag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff   <= '0;
         tag3_ff   <= '0;
         tag4_ff   <= '0;
         tagd_ff   <= '0;
         c_act_ff  <= 1'b0;
         c_last_ff <= 1'b0;
         c_hit_ff  <= 1'b0;
      end else begin
         tag2_ff   <= tag2_in;
         tag3_ff   <= tag2_ff;
         tag4_ff   <= tag3_ff;
         tagd_ff   <= tag5;
         c_act_ff  <= tagd_ff.act;
         c_last_ff <= tagd_ff.last;
         c_hit_ff  <= hit_in;
      end
   end

   pltb_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .v_i    (sum_ff),
      .tag_i  (tag4_ff),
      .root_o (root),
      .tag_o  (tag5)
   );

   // tile distance and contribution
   assign tile_dist = prod_ff[DIV_SHIFT +: ROOT_W];
   assign hit_in    = tagd_ff.act && tagd_ff.lv && (tile_dist < ROOT_W'(tagd_ff.reach));
   assign diff      = tagd_ff.reach - tile_dist[REACH_W-1:0];
   assign scaled    = diff * tagd_ff.base;

   // running maximum over the sweep
   always_comb begin
      best_in = best_ff;
      any_in  = any_ff || c_hit_ff;
      if (c_hit_ff && (c_ff > best_ff)) begin
         best_in = c_ff;
      end
      res_push       = c_act_ff && c_last_ff;
      res_new.any    = any_in;
      res_new.bright = (best_in > CONTRIB_W'(BRIGHT_CEIL)) ? BRIGHT_CEIL : best_in[BRIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff    <= '0;
         any_ff     <= 1'b0;
         res_wr_ff  <= 1'b0;
         res_rd_ff  <= 1'b0;
         res_cnt_ff <= '0;
      end else begin
         if (res_push) begin
            best_ff   <= '0;
            any_ff    <= 1'b0;
            res_wr_ff <= !res_wr_ff;
         end else if (c_act_ff) begin
            best_ff <= best_in;
            any_ff  <= any_in;
         end
         if (rsp_pop) begin
            res_rd_ff <= !res_rd_ff;
         end
         if (res_push && !rsp_pop) begin
            res_cnt_ff <= res_cnt_ff + 2'd1;
         end else if (rsp_pop && !res_push) begin
            res_cnt_ff <= res_cnt_ff - 2'd1;
         end
      end
   end

   // result buffer, two entries, never overfills thanks to the query credit
   always_ff @(posedge clock) begin
      if (res_push) begin
         res_ff[res_wr_ff] <= res_new;
      end
   end

   assign rsp_tvalid = (res_cnt_ff != '0);
   assign rsp_tdata  = {7'b0, res_ff[res_rd_ff].any, res_ff[res_rd_ff].bright};

endmodule

`default_nettype wire

// ===== rtl/point_light_tile_brightness.sv =====
// point_light_tile_brightness: top level, front queue plus back end executor
// depends on pltb_pkg, pltb_front, pltb_back (and through it pltb_ram, pltb_sqrt)
//
// Keeps a table of LIGHT_SLOTS point lights; a write beat (tuser 0) fills or
// clears one slot and gives no response, a query beat (tuser 1) returns the
// brightest light contribution at a tile, saturated at 255, with a flag that
// some light reaches it. A query sweeps the table at one slot per cycle, and
// the back end takes no other command until the sweep is done; the slots then
// pass through the distance, 13-stage square root and divide pipeline. Sweeps
// of two queries overlap with that pipeline, but only two queries may be
// outstanding against the two-entry response buffer, so a further query waits
// until a response has been taken. A two-entry request queue and the two-entry
// response buffer let either side stall independently.
// Reset clears the slot valid marks at once; no clearing pass is needed.
`default_nettype none

module point_light_tile_brightness
   import pltb_pkg::*;
#(
   parameter int LIGHT_SLOTS = 16,
   parameter int TILE_PIXELS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // slot_index[3:0], slot_enable[4], pos_x[16:5], pos_y[28:17],
   // reach[36:29], base_strength[44:37], zero pad[47:45]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // func[0]
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // brightness[7:0], any_light[8], zero pad[15:9]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // accept and classify request beats
   pltb_front #(
      .LIGHT_SLOTS (LIGHT_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready)
   );

   // table updates and query sweeps
   pltb_back #(
      .LIGHT_SLOTS (LIGHT_SLOTS),
      .TILE_PIXELS (TILE_PIXELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for point_light_tile_brightness, directed table then random beats
// depends on rtl/pltb_pkg.sv and rtl/point_light_tile_brightness.sv
`default_nettype none

module tb
   import pltb_pkg::*;
();

   localparam int SLOTS    = 16;
   localparam int TILE_PIX = 32;
   localparam int N_RANDOM = 2000;
   localparam int TAIL     = 64;

   // one request beat, field by field
   typedef struct {
      logic                  func;
      logic [SLOT_IDX_W-1:0] slot;
      logic                  enable;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [REACH_W-1:0]    reach;
      logic [BASE_W-1:0]     base;
   } lamp_cmd_type;

   // one response beat
   typedef struct {
      logic [BRIGHT_W-1:0] bright;
      logic                lit;
   } tile_result_type;

   // directed row; typed rows carry their own expected response
   typedef struct {
      lamp_cmd_type    cmd;
      bit              typed;
      tile_result_type want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = FUNC_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // light table as the block should hold it
   logic               lamp_on    [SLOTS];
   logic [COORD_W-1:0] lamp_x     [SLOTS];
   logic [COORD_W-1:0] lamp_y     [SLOTS];
   logic [REACH_W-1:0] lamp_reach [SLOTS];
   logic [BASE_W-1:0]  lamp_base  [SLOTS];

   tile_result_type brightness_q[$];
   plan_row_type    plan[$];

   int  n_errors    = 0;
   int  n_writes    = 0;
   int  n_queries   = 0;
   int  n_responses = 0;
   int  n_lit       = 0;
   int  n_saturated = 0;
   bit  calm        = 1'b0;

   point_light_tile_brightness #(
      .LIGHT_SLOTS(SLOTS),
      .TILE_PIXELS(TILE_PIX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, period 4
   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   // hard stop if the block hangs
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // alternate between stretches with idling and stretches without
   initial begin
      forever begin
         calm = 1'b0;
         repeat ($urandom_range(200, 900)) @(posedge clock);
         calm = 1'b1;
         repeat ($urandom_range(50, 300)) @(posedge clock);
      end
   end

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 60);
   endfunction

   // floor square root, one result bit per pass
   function automatic int unsigned floor_root(input int unsigned v);
      int unsigned r;
      int unsigned t;
      r = 0;
      for (int b = 12; b >= 0; b--) begin
         t = r | (32'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // brightest contribution at a tile over all active lights
   function automatic tile_result_type tile_brightness(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y);
      tile_result_type res;
      int              dx;
      int              dy;
      int unsigned     d;
      int unsigned     c;
      int unsigned     best;
      bit              lit;
      best = 0;
      lit  = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (lamp_on[i]) begin
            dx = int'(lamp_x[i]) - int'(x);
            dy = int'(lamp_y[i]) - int'(y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            d = floor_root(dx * dx + dy * dy) / TILE_PIX;
            if (d < lamp_reach[i]) begin
               c = ((lamp_reach[i] - d) * lamp_base[i]) >> 1;
               if (!lit || c > best) best = c;
               lit = 1'b1;
            end
         end
      end
      res.bright = (best > 255) ? BRIGHT_CEIL : best[BRIGHT_W-1:0];
      res.lit    = lit;
      return res;
   endfunction

   function automatic plan_row_type wr(input int slot, input bit en, input int x, input int y,
                                       input int reach, input int base);
      plan_row_type row;
      row.cmd   = '{FUNC_WRITE, slot[SLOT_IDX_W-1:0], en, x[COORD_W-1:0], y[COORD_W-1:0],
                    reach[REACH_W-1:0], base[BASE_W-1:0]};
      row.typed = 1'b0;
      row.want  = '{8'd0, 1'b0};
      return row;
   endfunction

   function automatic plan_row_type qy(input int x, input int y, input bit typed,
                                       input int bright, input bit lit);
      plan_row_type row;
      row.cmd   = '{FUNC_QUERY, '0, 1'b0, x[COORD_W-1:0], y[COORD_W-1:0], '0, '0};
      row.typed = typed;
      row.want  = '{bright[BRIGHT_W-1:0], lit};
      return row;
   endfunction

   // present one beat, wait for it to be taken, then update the table model or queue the expected response
   task automatic send_beat(input lamp_cmd_type cmd, input bit typed,
                            input tile_result_type want);
      int              gap;
      tile_result_type expect_res;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd.func;
      req_tdata  <= {3'b000, cmd.base, cmd.reach, cmd.y, cmd.x, cmd.enable, cmd.slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd.func == FUNC_WRITE) begin
         lamp_on[cmd.slot]    = cmd.enable;
         lamp_x[cmd.slot]     = cmd.x;
         lamp_y[cmd.slot]     = cmd.y;
         lamp_reach[cmd.slot] = cmd.reach;
         lamp_base[cmd.slot]  = cmd.base;
         n_writes++;
      end else begin
         expect_res = typed ? want : tile_brightness(cmd.x, cmd.y);
         brightness_q.insert(brightness_q.size(), expect_res);
         n_queries++;
      end
   endtask

   // coordinate near a point, clamped to the coordinate range
   function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c);
      int v;
      v = int'(c) + $urandom_range(0, 1200) - 600;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return COORD_W'($urandom_range(0, 4095));
   endfunction

   // random beat: writes build the table, queries mostly land near a light
   function automatic lamp_cmd_type random_cmd();
      lamp_cmd_type cmd;
      int           pick;
      int           on_slots[$];
      cmd.func   = ($urandom_range(0, 99) < 40) ? FUNC_WRITE : FUNC_QUERY;
      cmd.slot   = SLOT_IDX_W'($urandom_range(0, SLOTS - 1));
      cmd.enable = ($urandom_range(0, 3) != 0);
      cmd.x      = rand_coord();
      cmd.y      = rand_coord();
      cmd.reach  = REACH_W'(($urandom_range(0, 9) < 3) ? $urandom_range(0, 3)
                                                        : $urandom_range(0, 255));
      cmd.base   = BASE_W'(($urandom_range(0, 9) < 4) ? $urandom_range(0, 7)
                                                       : $urandom_range(0, 255));
      if (cmd.func == FUNC_QUERY) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (lamp_on[i]) on_slots.insert(on_slots.size(), i);
         end
         if (on_slots.size() != 0 && $urandom_range(0, 9) < 7) begin
            pick  = on_slots[$urandom_range(0, on_slots.size() - 1)];
            cmd.x = near_coord(lamp_x[pick]);
            cmd.y = near_coord(lamp_y[pick]);
         end
      end
      return cmd;
   endfunction

   // response side: random stalls on rsp_tready
   initial begin
      int run;
      int stall;
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         run = $urandom_range(1, 40);
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      tile_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_responses++;
         if (brightness_q.size() == 0) begin
            $error("response beat with no query outstanding: tdata %h", rsp_tdata);
            n_errors++;
         end else begin
            want = brightness_q.pop_front();
            if (rsp_tdata[BRIGHT_W-1:0] !== want.bright) begin
               $error("brightness: expected %0d, got %0d", want.bright,
                      rsp_tdata[BRIGHT_W-1:0]);
               n_errors++;
            end
            if (rsp_tdata[BRIGHT_W] !== want.lit) begin
               $error("any_light: expected %0d, got %0d", want.lit, rsp_tdata[BRIGHT_W]);
               n_errors++;
            end
            if (want.lit) n_lit++;
            if (want.bright == BRIGHT_CEIL) n_saturated++;
         end
      end
   end

   // stimulus: reset, directed table, random beats, drain
   initial begin
      tile_result_type none;
      none = '{8'd0, 1'b0};
      for (int i = 0; i < SLOTS; i++) begin
         lamp_on[i] = 1'b0;
      end
      plan = '{
         qy(0, 0, 1, 0, 0),                     // empty table
         qy(4095, 4095, 1, 0, 0),
         wr(0, 1, 0, 0, 255, 255),              // strongest light in a corner
         qy(0, 0, 1, 255, 1),                   // saturates
         qy(4095, 4095, 0, 0, 0),               // far corner, still in reach
         wr(0, 0, 0, 0, 255, 255),              // slot removal
         qy(0, 0, 1, 0, 0),
         wr(15, 1, 4095, 4095, 1, 1),           // reaches but contributes zero
         qy(4095, 4095, 1, 0, 1),
         wr(15, 1, 4095, 4095, 255, 0),         // base zero, wide reach
         qy(0, 0, 1, 0, 1),
         wr(15, 0, 4095, 4095, 255, 0),
         wr(7, 1, 0, 0, 2, 3),                  // edge of the reach
         qy(63, 0, 0, 0, 0),
         qy(64, 0, 0, 0, 0),
         wr(3, 1, 2048, 2048, 0, 255),          // zero reach never lights
         qy(2048, 2048, 1, 0, 0),
         wr(9, 1, 1000, 3000, 20, 25),
         wr(10, 1, 1010, 2990, 5, 200),
         qy(1000, 3000, 0, 0, 0),
         qy(1320, 3000, 0, 0, 0),
         wr(8, 1, 2730, 1365, 170, 85),         // alternating bit patterns
         qy(1365, 2730, 0, 0, 0),
         wr(6, 1, 4095, 0, 255, 1),
         qy(4095, 0, 0, 0, 0)
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         send_beat(plan[i].cmd, plan[i].typed, plan[i].want);
      end
      repeat (N_RANDOM) begin
         send_beat(random_cmd(), 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (brightness_q.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);

      $display("covered %0d slot writes and %0d tile queries, %0d responses checked",
               n_writes, n_queries, n_responses);
      $display("%0d queries found a light, %0d of them saturated", n_lit, n_saturated);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
